@@ src/ilst_pkg.sv @@
// Shared types and constants for the indexed list store.
// Used by ilst_cell and indexed_list_store_unit; depends on nothing.
`default_nettype none

package ilst_pkg;

  // Field widths of the command and response beats
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned LENGTH_W = 7;
  localparam int unsigned STATUS_W = 2;

  // Default sizing
  localparam int unsigned DEPTH_DEF      = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Command kinds
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Per-cycle control broadcast to every entry cell
  typedef struct packed {
    logic             append; // store word at the tail
    logic             write;  // store word at pos
    logic             remove; // cells at or above pos take the upper neighbor
    logic [POS_W-1:0] pos;
  } ilst_ctrl_t;

endpackage : ilst_pkg

`default_nettype wire

@@ src/ilst_cell.sv @@
// One entry cell of the list chain: holds one word, loads it from the command,
// takes its upper neighbor on remove, and offers its word for a read.
// Depends on ilst_pkg.
`default_nettype none

module ilst_cell #(
  parameter int unsigned DATA_WIDTH = ilst_pkg::DATA_WIDTH_DEF,
  parameter int unsigned CNT_W      = 7,
  parameter int unsigned IDX        = 0
) (
  input  wire logic                  clk,
  input  wire ilst_pkg::ilst_ctrl_t  ctrl,
  input  wire logic [CNT_W-1:0]      tail,
  input  wire logic [DATA_WIDTH-1:0] word,
  input  wire logic [DATA_WIDTH-1:0] upper,
  output logic      [DATA_WIDTH-1:0] data,
  output logic      [DATA_WIDTH-1:0] rd
);

  logic at_pos;
  logic above_pos;
  logic at_tail;

  // Compare this cell's place with the command position and the tail
  assign at_pos    = 32'(ctrl.pos) == 32'(IDX);
  assign above_pos = 32'(IDX) >= 32'(ctrl.pos);
  assign at_tail   = tail == CNT_W'(IDX);

  // Load on append or write, shift down on remove, hold otherwise
  always_ff @(posedge clk) begin
    if ((ctrl.append && at_tail) || (ctrl.write && at_pos)) begin
      data <= word;
    end else if (ctrl.remove && above_pos) begin
      data <= upper;
    end
  end

  // Offer the word only when this cell is addressed
  assign rd = at_pos ? data : '0;

endmodule : ilst_cell

`default_nettype wire

@@ src/indexed_list_store_unit.sv @@
// Indexed list store: a positional list of words kept in a chain of entry cells.
// Channels: cmd (kind, position, value) in, rsp (read_value, length, status) out,
//   both valid/ready; a beat moves when valid and ready are high at a clock edge.
// Each command is decoded against the current length, every entry cell updates
//   in parallel at the accepting edge (remove shifts all later cells down one
//   place at once), and the response is registered.
// Latency: the response is valid the cycle after the command beat.
// Throughput: one command per cycle while rsp_ready is high; the single
//   response register is the only buffer, so cmd_ready is high when it is empty
//   or being drained in the same cycle.
// Read picks the addressed cell through an OR of the cells' gated outputs.
// A stalled receiver holds the response; cmd_ready then drops until it is taken.
// Reset (synchronous, rst high) clears the length and the response valid; the
//   entry words are not cleared, since only entries below the length are read.
// Errors: an index at or beyond the length gives status range, an append to a
//   full list gives status full; neither changes the list.
// Depends on ilst_pkg and ilst_cell.
`default_nettype none

module indexed_list_store_unit #(
  parameter int unsigned DEPTH      = ilst_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = ilst_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cmd_valid,
  output logic                                  cmd_ready,
  input  wire logic [ilst_pkg::KIND_W-1:0]      kind,
  input  wire logic [ilst_pkg::POS_W-1:0]       position,
  input  wire logic [ilst_pkg::VALUE_W-1:0]     value,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output logic      [ilst_pkg::VALUE_W-1:0]     read_value,
  output logic      [ilst_pkg::LENGTH_W-1:0]    length,
  output logic      [ilst_pkg::STATUS_W-1:0]    status
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;
  logic                        accept;
  logic                        is_append;
  logic                        full;
  logic                        out_of_range;
  logic                        ok;
  logic [ilst_pkg::STATUS_W-1:0] status_next;
  ilst_pkg::ilst_ctrl_t        ctrl;
  logic [DATA_WIDTH-1:0]       word;
  logic [DATA_WIDTH-1:0]       cell_data [DEPTH];
  logic [DATA_WIDTH-1:0]       cell_rd   [DEPTH];
  logic [DATA_WIDTH-1:0]       rd_any;

  // Take a command when the response register is free or draining
  assign cmd_ready = !rsp_valid || rsp_ready;
  assign accept    = cmd_valid && cmd_ready;

  // Decode the command against the current length
  assign word         = DATA_WIDTH'(value);
  assign is_append    = kind == ilst_pkg::KIND_APPEND;
  assign full         = count == CNT_W'(DEPTH);
  assign out_of_range = !is_append && (32'(position) >= 32'(count));

  always_comb begin
    status_next = ilst_pkg::ST_OK;
    if (is_append && full) begin
      status_next = ilst_pkg::ST_FULL;
    end else if (out_of_range) begin
      status_next = ilst_pkg::ST_RANGE;
    end
  end

  assign ok = accept && (status_next == ilst_pkg::ST_OK);

  // Broadcast control to the cells
  always_comb begin
    ctrl.append = ok && is_append;
    ctrl.write  = ok && (kind == ilst_pkg::KIND_WRITE);
    ctrl.remove = ok && (kind == ilst_pkg::KIND_REMOVE);
    ctrl.pos    = position;
  end

  // Grow on append, shrink on remove
  always_comb begin
    count_next = count;
    if (ctrl.append) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.remove) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Chain of entry cells; the top cell feeds itself on remove
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] upper;
    if (i == DEPTH - 1) begin : g_top
      assign upper = cell_data[i];
    end else begin : g_mid
      assign upper = cell_data[i+1];
    end

    ilst_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .tail (count),
      .word (word),
      .upper(upper),
      .data (cell_data[i]),
      .rd   (cell_rd[i])
    );
  end

  // Merge the gated cell outputs; at most one is nonzero
  always_comb begin
    rd_any = '0;
    for (int j = 0; j < DEPTH; j++) begin
      rd_any = rd_any | cell_rd[j];
    end
  end

  // Response valid: set on a command beat, drop when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      length <= ilst_pkg::LENGTH_W'(count_next);
      if (ok && (kind == ilst_pkg::KIND_READ)) begin
        read_value <= ilst_pkg::VALUE_W'(rd_any);
      end else begin
        read_value <= '0;
      end
    end
  end

endmodule : indexed_list_store_unit

`default_nettype wire
